### hdl/ipcs_pkg.sv
// Shared types and constants for the identifier prefix completion select unit.
package ipcs_pkg;

  localparam int MAX_TOKEN   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int DEPTH       = 2 * MAX_TOKEN;
  localparam int AW          = $clog2(DEPTH);
  localparam int TW          = $clog2(MAX_TOKEN + 1);
  localparam int CW          = $clog2(MAX_RESULTS + 1);
  localparam int PREFIX_MAX  = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_TEXT   = 2'd1,
    REQ_FINISH = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PFX_CHARS = 1'b0,
    REG_PFX_LEN   = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } ord_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] ch;
  } ipcs_in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] suffix_char;
    logic       last;
  } ipcs_out_t;

endpackage

### hdl/ipcs_store.sv
// Two-bank character store: one write port, one registered read port.
module ipcs_store (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ipcs_pkg::AW-1:0] waddr_i,
  input  logic [7:0]             wdata_i,
  input  logic                   re_i,
  input  logic [ipcs_pkg::AW-1:0] raddr_i,
  output logic [7:0]             rdata_o
);
  import ipcs_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/identifier_prefix_completion_select_unit.sv
// Top level of the identifier prefix completion select unit.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per request.
//   clear  : forgets the kept identifier and any pending token, no result.
//   text   : one byte of the stream; identifiers are split out on the fly.
//   finish : closes a pending token, then reports the kept identifier.
// Output channel (out_valid_o / out_stall_i / out_data_o): a finish gives a
//   run of suffix-character beats (at most 32, last flagged) or one
//   not-found beat with found low.
// Config port: cfg_we_i writes prefix_chars (index 0) or the prefix length (1).
// Sequencing: a text byte is taken in ST_IDLE, and also passes ST_BYTE when it
//   must be compared against the kept identifier (registered char store read).
//   A finish passes ST_FIN for the kept-length check, then ST_EMIT_RD (read
//   issue) and ST_EMIT_WR (load of the output register) per suffix beat; a
//   not-found beat is loaded from ST_FIN itself.
// The output register decouples the sides: a new request is taken while a
//   finished beat still waits. A stalled receiver holds the output beat
//   and, during a run, holds the emit sequencer.
// Reset clears all control state; the char store needs no clearing since
//   only entries written earlier are ever read.
module identifier_prefix_completion_select_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ipcs_pkg::ipcs_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ipcs_pkg::ipcs_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ipcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ipcs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ipcs_pkg::*;

  localparam int SW = (TW > CW) ? TW : CW;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Config registers
  logic [63:0] prefix_chars_q;
  logic [3:0]  pfx_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_chars_q <= '0;
      pfx_len_q      <= 4'd1;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_PFX_CHARS: prefix_chars_q <= cfg_data_i;
        REG_PFX_LEN:   pfx_len_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective prefix length saturates at eight
  logic [TW-1:0] plen;
  assign plen = (pfx_len_q > 4'(PREFIX_MAX)) ? TW'(PREFIX_MAX) : TW'(pfx_len_q);

  // Control and token state
  state_e        state_q, state_d;
  logic          bank_q, bank_d;
  logic [TW-1:0] tok_len_q, tok_len_d;
  logic [TW-1:0] best_len_q, best_len_d;
  logic          in_tok_q, in_tok_d;
  logic          pmatch_q, pmatch_d;
  ord_e          ord_q, ord_d;
  logic          too_long_q, too_long_d;
  logic [7:0]    byte_q, byte_d;
  logic [TW-1:0] pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Output register
  logic          out_valid_q;
  ipcs_out_t     out_q, out_d;
  logic          out_load;
  logic          slot_free;

  // Char store ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Scratch for the text path
  logic [TW-1:0] p;
  logic          tl, pm, take, take_best;
  ord_e          ord_base;
  logic [7:0]    c;
  logic [7:0]    pbyte;
  logic [SW-1:0] diff;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign c          = in_data_i.ch;
  assign pbyte      = prefix_chars_q[{p[2:0], 3'b000} +: 8];

  // Prefix match, longer than prefix: kept when shorter, or equal and smaller
  assign take_best = in_tok_q && !too_long_q && pmatch_q && (tok_len_q > plen) &&
                     ((best_len_q == '0) || (tok_len_q < best_len_q) ||
                      ((tok_len_q == best_len_q) && (ord_q == ORD_LESS)));

  always_comb begin
    state_d    = state_q;
    bank_d     = bank_q;
    tok_len_d  = tok_len_q;
    best_len_d = best_len_q;
    in_tok_d   = in_tok_q;
    pmatch_d   = pmatch_q;
    ord_d      = ord_q;
    too_long_d = too_long_q;
    byte_d     = byte_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    out_load   = 1'b0;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    mem_raddr  = '0;
    mem_wdata  = c;
    p          = in_tok_q ? tok_len_q : '0;
    tl         = in_tok_q ? too_long_q : 1'b0;
    pm         = in_tok_q ? pmatch_q : 1'b1;
    ord_base   = in_tok_q ? ord_q : ORD_EQUAL;
    take       = in_tok_q ? is_word(c) : is_letter(c);
    diff       = SW'(best_len_q) - SW'(plen);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.req_type)
            REQ_CLEAR: begin
              best_len_d = '0;
              in_tok_d   = 1'b0;
              tok_len_d  = '0;
              pmatch_d   = 1'b1;
              ord_d      = ORD_EQUAL;
              too_long_d = 1'b0;
            end
            REQ_TEXT: begin
              if (in_tok_q && !is_word(c)) begin
                in_tok_d = 1'b0;
                if (take_best) begin
                  bank_d     = !bank_q;
                  best_len_d = tok_len_q;
                end
              end else if (take) begin
                in_tok_d  = 1'b1;
                pmatch_d  = pm;
                ord_d     = ord_base;
                tok_len_d = p;
                if (tl || p >= TW'(MAX_TOKEN)) begin
                  too_long_d = 1'b1;
                end else begin
                  too_long_d = 1'b0;
                  mem_we     = 1'b1;
                  mem_waddr  = (bank_q ? AW'(0) : AW'(MAX_TOKEN)) + AW'(p);
                  if (p < plen && c != pbyte) begin
                    pmatch_d = 1'b0;
                  end
                  tok_len_d = p + TW'(1);
                  // compare against the kept token at the same position
                  if (ord_base == ORD_EQUAL && p < best_len_q) begin
                    mem_re    = 1'b1;
                    mem_raddr = (bank_q ? AW'(MAX_TOKEN) : AW'(0)) + AW'(p);
                    byte_d    = c;
                    state_d   = ST_BYTE;
                  end
                end
              end
            end
            REQ_FINISH: begin
              in_tok_d = 1'b0;
              if (take_best) begin
                bank_d     = !bank_q;
                best_len_d = tok_len_q;
              end
              state_d = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_BYTE: begin
        if (byte_q < mem_rdata) begin
          ord_d = ORD_LESS;
        end else if (byte_q > mem_rdata) begin
          ord_d = ORD_GREATER;
        end
        state_d = ST_IDLE;
      end
      ST_FIN: begin
        if (best_len_q <= plen) begin
          if (slot_free) begin
            out_load          = 1'b1;
            out_d.found       = 1'b0;
            out_d.suffix_char = '0;
            out_d.last        = 1'b1;
            state_d           = ST_IDLE;
          end
        end else begin
          pos_d   = plen;
          cnt_d   = (diff > SW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : CW'(diff);
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = (bank_q ? AW'(MAX_TOKEN) : AW'(0)) + AW'(pos_q);
        state_d   = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_d.found       = 1'b1;
          out_d.suffix_char = (pos_q < TW'(MAX_TOKEN)) ? mem_rdata : 8'h00;
          out_d.last        = (cnt_q == CW'(1));
          pos_d             = pos_q + TW'(1);
          cnt_d             = cnt_q - CW'(1);
          state_d           = (cnt_q == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bank_q     <= 1'b0;
      tok_len_q  <= '0;
      best_len_q <= '0;
      in_tok_q   <= 1'b0;
      pmatch_q   <= 1'b1;
      ord_q      <= ORD_EQUAL;
      too_long_q <= 1'b0;
      pos_q      <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      bank_q     <= bank_d;
      tok_len_q  <= tok_len_d;
      best_len_q <= best_len_d;
      in_tok_q   <= in_tok_d;
      pmatch_q   <= pmatch_d;
      ord_q      <= ord_d;
      too_long_q <= too_long_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ipcs_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### bench/identifier_prefix_completion_select_unit_tb.sv
// Self-checking testbench for the identifier prefix completion select unit.
module identifier_prefix_completion_select_unit_tb;
  import ipcs_pkg::*;

  // Request code 3 is not decoded by the block: it must be dropped silently.
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam logic [7:0] UNDERSCORE    = "_";
  localparam int         RANDOM_ITEMS  = 250;
  // Quiet cycles after the last beat before touching config, so that any
  // tail work of the last request has finished.
  localparam int         SETTLE_CYCLES = 12;
  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         HOLD_CYCLES   = 250;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  ipcs_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  ipcs_out_t out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  identifier_prefix_completion_select_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Requests waiting to go out, and suffix beats the block still owes us.
  ipcs_in_t  stim_q[$];
  ipcs_out_t suffix_beats_q[$];

  // Knobs shared by the sender, the receiver and the tests.
  bit calm;          // no idling on either side while set (a requested hold still runs)
  int hold_req;      // receiver: clear, then stall this many cycles
  bit hold_active;

  int err_cnt;
  int issued_cnt;
  int finish_cnt;
  int miss_cnt;
  int drop_cnt;
  int checked_beats;
  int in_stall_cycles;
  int cycle_cnt;

  // ---------------------------------------------------------------------
  // Shadow of the block: prefix config, the two token banks, and the
  // running state of the token being scanned.
  // ---------------------------------------------------------------------
  logic [63:0] m_pfx_chars;
  logic [3:0]  m_pfx_len;
  logic [7:0]  m_store [2][MAX_TOKEN];
  bit          m_best_bank;    // bank holding the kept identifier
  int unsigned m_tok_len;
  int unsigned m_best_len;     // zero: nothing kept yet
  bit          m_in_tok;
  bit          m_pfx_ok;
  ord_e        m_ord;          // scanned token against the kept one so far
  bit          m_overflow;

  function automatic bit is_ident_lead(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == UNDERSCORE;
  endfunction

  function automatic bit is_ident_tail(logic [7:0] c);
    return is_ident_lead(c) || (c >= "0" && c <= "9");
  endfunction

  // Prefix lengths above eight saturate.
  function automatic int unsigned eff_len();
    return (m_pfx_len > PREFIX_MAX) ? PREFIX_MAX : m_pfx_len;
  endfunction

  function automatic void reset_model();
    foreach (m_store[b, i]) m_store[b][i] = 8'h00;
    m_pfx_chars = '0;
    m_pfx_len   = 4'd1;
    m_best_bank = 1'b0;
    m_tok_len   = 0;
    m_best_len  = 0;
    m_in_tok    = 1'b0;
    m_pfx_ok    = 1'b1;
    m_ord       = ORD_EQUAL;
    m_overflow  = 1'b0;
  endfunction

  function automatic void append_char(logic [7:0] c);
    int unsigned p;
    logic [7:0]  kept;
    p = m_tok_len;
    // Past MAX_TOKEN the token is poisoned until it ends.
    if (m_overflow || p >= MAX_TOKEN) begin
      m_overflow = 1'b1;
      return;
    end
    m_store[!m_best_bank][p] = c;
    if (p < eff_len() && c != m_pfx_chars[p*8 +: 8]) m_pfx_ok = 1'b0;
    // First differing byte decides the tie-break order.
    if (m_ord == ORD_EQUAL && p < m_best_len) begin
      kept = m_store[m_best_bank][p];
      if (c < kept) m_ord = ORD_LESS;
      else if (c > kept) m_ord = ORD_GREATER;
    end
    m_tok_len = p + 1;
  endfunction

  function automatic void close_token();
    bit take;
    if (!m_in_tok) return;
    m_in_tok = 1'b0;
    if (m_overflow) drop_cnt++;
    if (m_overflow || !m_pfx_ok || m_tok_len <= eff_len()) return;
    take = (m_best_len == 0) || (m_tok_len < m_best_len) ||
           (m_tok_len == m_best_len && m_ord == ORD_LESS);
    if (take) begin
      m_best_bank = !m_best_bank;
      m_best_len  = m_tok_len;
    end
  endfunction

  // Applies one accepted request and queues the suffix beats it must cause.
  function automatic void predict_completion(ipcs_in_t item);
    int unsigned plen;
    int unsigned n;
    ipcs_out_t   beat;
    case (item.req_type)
      REQ_CLEAR: begin
        m_best_len = 0;
        m_in_tok   = 1'b0;
        m_tok_len  = 0;
        m_pfx_ok   = 1'b1;
        m_ord      = ORD_EQUAL;
        m_overflow = 1'b0;
      end
      REQ_TEXT: begin
        if (m_in_tok) begin
          if (is_ident_tail(item.ch)) append_char(item.ch);
          else close_token();
        end else if (is_ident_lead(item.ch)) begin
          m_in_tok   = 1'b1;
          m_tok_len  = 0;
          m_pfx_ok   = 1'b1;
          m_ord      = ORD_EQUAL;
          m_overflow = 1'b0;
          append_char(item.ch);
        end
      end
      REQ_FINISH: begin
        close_token();
        finish_cnt++;
        plen = eff_len();
        if (m_best_len <= plen) begin
          beat = '{found: 1'b0, suffix_char: 8'h00, last: 1'b1};
          suffix_beats_q.push_back(beat);
          miss_cnt++;
        end else begin
          n = m_best_len - plen;
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          for (int unsigned k = 0; k < n; k++) begin
            beat.found       = 1'b1;
            beat.suffix_char = (plen + k < MAX_TOKEN) ? m_store[m_best_bank][plen + k] : 8'h00;
            beat.last        = (k + 1 == n);
            suffix_beats_q.push_back(beat);
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender: pops stim_q, holds each beat until it is taken. Valid only
  // drops when the next beat is not offered right away, so it never sees
  // two updates in one step. Stall is sampled at the falling edge, when
  // every input has settled since the last rising edge.
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : feeder
    int gap;
    bit taken;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stim_q.size() == 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        in_valid_i <= 1'b1;
        in_data_i  <= stim_q[0];
        do begin
          @(negedge clk_i);
          taken = (in_stall_o === 1'b0);
          @(posedge clk_i);
        end while (!taken);
        predict_completion(stim_q[0]);
        void'(stim_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, free-running stretches, and on request
  // one long hold so the block backs up into its input.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int run;
    int r;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        run         = hold_req;
        hold_req    = 0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (run) @(posedge clk_i);
        hold_active = 1'b0;
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(1, 12);
        end else if (r < 9) begin
          out_stall_i <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Scoreboard: every beat taken is matched against the oldest expectation.
  // ---------------------------------------------------------------------
  initial begin : scoreboard
    ipcs_out_t want;
    ipcs_out_t got;
    forever begin
      @(negedge clk_i);
      if (in_valid_i === 1'b1 && in_stall_o === 1'b1) in_stall_cycles++;
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = out_data_o;
        if (suffix_beats_q.size() == 0) begin
          $error("unexpected beat: found=%0b suffix_char=%02h last=%0b",
                 got.found, got.suffix_char, got.last);
          err_cnt++;
        end else begin
          want = suffix_beats_q.pop_front();
          checked_beats++;
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            err_cnt++;
          end
          if (got.suffix_char !== want.suffix_char) begin
            $error("suffix_char: expected %02h, got %02h", want.suffix_char, got.suffix_char);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_item(logic [1:0] req, logic [7:0] c);
    ipcs_in_t item;
    item.req_type = req;
    item.ch       = c;
    stim_q.push_back(item);
    if (req != REQ_UNUSED) issued_cnt++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(REQ_TEXT, s[i]);
  endtask

  // Small alphabets so that equal lengths and shared heads come up often.
  function automatic logic [7:0] pick_lead_char();
    case ($urandom_range(0, 4))
      0:       return "a";
      1:       return "b";
      2:       return "Z";
      3:       return "q";
      default: return UNDERSCORE;
    endcase
  endfunction

  function automatic logic [7:0] pick_tail_char();
    case ($urandom_range(0, 5))
      0:       return "a";
      1:       return "b";
      2:       return "z";
      3:       return "Z";
      4:       return "9";
      default: return UNDERSCORE;
    endcase
  endfunction

  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    do c = 8'($urandom); while (is_ident_tail(c));
    return c;
  endfunction

  function automatic int unsigned random_tail();
    if ($urandom_range(0, 11) == 0) return $urandom_range(20, 36);
    return $urandom_range(0, 4);
  endfunction

  // One identifier: either the current prefix followed by a tail, or a free one.
  task automatic send_token(bit on_prefix, int unsigned tail_len);
    int unsigned plen;
    plen = eff_len();
    if (on_prefix && plen > 0) begin
      for (int unsigned i = 0; i < plen; i++) send_item(REQ_TEXT, m_pfx_chars[i*8 +: 8]);
    end else begin
      send_item(REQ_TEXT, pick_lead_char());
    end
    repeat (tail_len) send_item(REQ_TEXT, pick_tail_char());
  endtask

  task automatic send_noise();
    logic [1:0] req;
    req = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) : REQ_TEXT;
    send_item(req, 8'($urandom));
  endtask

  // Drains everything in flight, then lets the block go quiet.
  task automatic wait_idle();
    while (stim_q.size() != 0 || suffix_beats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers on back-to-back edges; call only when idle.
  task automatic set_prefix(logic [63:0] chars, logic [3:0] len);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PFX_CHARS;
    cfg_data_i <= chars;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PFX_LEN;
    cfg_data_i <= {{(CFG_DATA_W-4){1'b0}}, len};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    m_pfx_chars = chars;
    m_pfx_len   = len;
  endtask

  task automatic random_prefix();
    logic [63:0] chars;
    logic [3:0]  len;
    int unsigned plen;
    int          r;
    r = $urandom_range(0, 9);
    if (r == 0) len = 4'd0;
    else if (r == 1) len = 4'd8;
    else if (r == 2) len = 4'($urandom_range(9, 15));
    else if (r == 3) len = 4'($urandom_range(4, 7));
    else len = 4'($urandom_range(1, 3));
    plen = (len > PREFIX_MAX) ? PREFIX_MAX : len;
    if ($urandom_range(0, 7) == 0) begin
      chars = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (i >= plen) chars[i*8 +: 8] = 8'($urandom);
        else if (i == 0) chars[i*8 +: 8] = pick_lead_char();
        else chars[i*8 +: 8] = pick_tail_char();
      end
    end
    set_prefix(chars, len);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every request code, separators at both byte extremes, a tie broken by
  // byte order, a digit outside a token, finish inside a token, a repeat
  // finish that reuses the kept identifier, and clear.
  task automatic test_basic_ops();
    wait_idle();
    set_prefix(64'h61, 4'd1);           // "a"
    send_item(REQ_CLEAR, 8'h00);
    send_text("_Z9 ax");
    send_item(REQ_TEXT, 8'h00);
    send_text("ab");
    send_item(REQ_UNUSED, "q");
    send_item(REQ_TEXT, 8'hFF);
    send_text("9aa");                   // digit skipped, then a new token
    send_item(REQ_FINISH, 8'h00);       // closes "aa"
    send_item(REQ_FINISH, 8'hFF);       // same answer again
    send_item(REQ_CLEAR, 8'hFF);
    send_item(REQ_FINISH, 8'h00);       // nothing kept: not found
  endtask

  // Full eight-byte prefix written with an out-of-range length, then the
  // empty prefix.
  task automatic test_prefix_extremes();
    wait_idle();
    set_prefix(64'h6867_6665_6463_6261, 4'd15);   // "abcdefgh", saturates
    send_item(REQ_CLEAR, 8'h00);
    send_text("abcdefghi abcdefgh");
    send_item(REQ_FINISH, 8'h00);
    wait_idle();
    set_prefix(64'h0, 4'd0);
    send_item(REQ_CLEAR, 8'h00);
    send_text("b1 Q");
    send_item(REQ_FINISH, 8'h00);
  endtask

  // A token one byte past the limit is dropped even when finish ends it.
  task automatic test_token_length();
    wait_idle();
    set_prefix(64'h0, 4'd0);
    send_item(REQ_CLEAR, 8'h00);
    send_text("ab ");
    send_token(1'b0, MAX_TOKEN);
    send_item(REQ_FINISH, 8'h00);
  endtask

  // Longest suffix runs against a receiver that holds off for a long time,
  // with the sender pushing back to back so the input side must stall.
  task automatic test_output_backpressure();
    wait_idle();
    set_prefix(64'h0, 4'd0);
    hold_req = HOLD_CYCLES;
    wait (hold_active);
    calm = 1'b1;
    send_item(REQ_CLEAR, 8'h00);
    send_token(1'b0, MAX_TOKEN - 1);
    repeat (4) send_item(REQ_FINISH, 8'h00);
    send_text(" ab");
    send_item(REQ_FINISH, 8'h00);
    wait_idle();
    calm = 1'b0;
  endtask

  // Mostly well-formed search sessions with random content; noise, unused
  // codes, stray clears and missing separators mixed in.
  task automatic test_random_streams();
    int start_cnt;
    int n_tok;
    int pick;
    start_cnt = issued_cnt;
    while (issued_cnt - start_cnt < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        wait_idle();
        random_prefix();
      end
      if ($urandom_range(0, 7) != 0) send_item(REQ_CLEAR, 8'($urandom));
      n_tok = $urandom_range(1, 6);
      for (int i = 0; i < n_tok; i++) begin
        pick = $urandom_range(0, 11);
        if (pick < 8) send_token(1'b1, random_tail());
        else if (pick < 10) send_token(1'b0, random_tail());
        else repeat ($urandom_range(1, 4)) send_noise();
        if (i + 1 < n_tok || $urandom_range(0, 2) != 0) send_item(REQ_TEXT, pick_separator());
        if ($urandom_range(0, 9) == 0) send_item(REQ_UNUSED, 8'($urandom));
      end
      send_item(REQ_FINISH, 8'($urandom));
      if ($urandom_range(0, 5) == 0) send_item(REQ_FINISH, 8'($urandom));
    end
    wait_idle();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_PFX_CHARS;
    cfg_data_i <= '0;
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_prefix_extremes();
    test_token_length();
    test_output_backpressure();
    test_random_streams();
    wait_idle();

    $display("Sent %0d requests: %0d finish reports, %0d of them not found, %0d long tokens dropped.",
             issued_cnt, finish_cnt, miss_cnt, drop_cnt);
    $display("Checked %0d suffix beats; input was held off for %0d cycles.",
             checked_beats, in_stall_cycles);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
